>>> rtl/dofd_pkg.sv
`default_nettype none
package dofd_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 5;
   localparam int MAX_EMIT      = 16;
   localparam int LEFT_W        = $clog2(MAX_EMIT + 1);

   localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(16);

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DRAIN   = 1'b1;

   typedef struct packed {
      logic                      operation;
      logic signed [VALUE_W-1:0] item_value;
      logic [COUNT_W-1:0]        drain_count;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic                      last_of_run;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/dofd_cell.sv
`default_nettype none
module dofd_cell
   import dofd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      shift_en,
   input  wire logic signed [VALUE_W-1:0] value_in,
   output logic signed [VALUE_W-1:0]      value_out
);

   logic signed [VALUE_W-1:0] value_ff;

   // take value_in (the neighbor's entry, or the new item at the head) on every enqueue
   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= value_in;
      end
   end

   assign value_out = value_ff;

endmodule
`default_nettype wire

>>> rtl/drop_oldest_drain_fifo_core.sv
`default_nettype none
// Bounded queue of signed 32-bit values that drops its oldest entry when full.
// Request channel: present req_payload with start high; a request is taken at
// a rising edge where start is high and busy is low. An enqueue request
// stores item_value; if the queue already holds the capacity, the oldest
// entries are discarded first. A drain request emits up to drain_count of
// the oldest entries (at most 16, at most what is stored).
// Result channel: each result sits on rsp_payload for one cycle with
// rsp_valid high; last_of_run marks the final entry of a drain. The receiver
// cannot stall, so results leave at one per cycle.
// Timing: busy stays low for an enqueue, so enqueues run back to back. A
// drain of n entries holds busy while the run counter left_ff is nonzero,
// one entry read per cycle from the tail of the cell chain; the request
// loads left_ff, each read is registered into rsp_payload, and the results
// follow on consecutive cycles. A drain that emits nothing leaves busy low.
// csr_we/csr_wdata write the capacity (0 acts as 1, above DEPTH saturates).
// Reset empties the queue and sets the capacity to 16; entry data is not
// cleared.
module drop_oldest_drain_fifo_core
   import dofd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire req_type            req_payload,
   output logic                    busy,
   output logic                    rsp_valid,
   output rsp_type                 rsp_payload,
   input  wire logic               csr_we,
   input  wire logic [COUNT_W-1:0] csr_wdata
);

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

   logic [COUNT_W-1:0]        cap_ff;
   logic [OCC_W-1:0]          occ_ff,  occ_in;
   logic [LEFT_W-1:0]         left_ff, left_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff,  rsp_in;

   logic signed [VALUE_W-1:0] cell_q [DEPTH];
   logic                      accept, enq, drain, emit;
   logic [CMP_W-1:0]          cap_eff, occ_ext, cnt;
   logic signed [VALUE_W-1:0] tail_value;

   assign accept = start && !busy;
   assign enq    = accept && (req_payload.operation == OP_ENQUEUE);
   assign drain  = accept && (req_payload.operation == OP_DRAIN);
   assign emit   = (left_ff != '0);
   assign busy   = emit;

   // newest entry lives in cell 0, oldest in cell occ-1
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         dofd_cell u_cell (
            .clock     (clock),
            .shift_en  (enq),
            .value_in  (req_payload.item_value),
            .value_out (cell_q[i])
         );
      end else begin : g_body
         dofd_cell u_cell (
            .clock     (clock),
            .shift_en  (enq),
            .value_in  (cell_q[i-1]),
            .value_out (cell_q[i])
         );
      end
   end

   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (occ_ff == OCC_W'(i + 1)) begin
            tail_value = cell_q[i];
         end
      end
   end

   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_eff == '0) begin
         cap_eff = CMP_W'(1);
      end
      if (cap_eff > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end
      occ_ext = CMP_W'(occ_ff);

      cnt = CMP_W'(req_payload.drain_count);
      if (cnt > occ_ext) begin
         cnt = occ_ext;
      end
      if (cnt > CMP_W'(MAX_EMIT)) begin
         cnt = CMP_W'(MAX_EMIT);
      end

      occ_in       = occ_ff;
      left_in      = left_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (enq) begin
         // drop oldest entries down to one below capacity, then store
         if (occ_ext >= cap_eff) begin
            occ_in = OCC_W'(cap_eff);
         end else begin
            occ_in = occ_ff + OCC_W'(1);
         end
      end else if (drain) begin
         left_in = LEFT_W'(cnt);
      end else if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_value    = tail_value;
         rsp_in.last_of_run  = (left_ff == LEFT_W'(1));
         occ_in              = occ_ff - OCC_W'(1);
         left_in             = left_ff - LEFT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         occ_ff       <= occ_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
